>>> hw/rtl/laq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Leak alarm qualifier package
// Shared widths, operation codes, register indexes, reset values and the
// fixed-point reciprocal used to divide the scaled baseline by one hundred.
// ----------------------------------------------------------------------------
package laq_pkg;

	// Field widths fixed by the interface.
	localparam int OP_W    = 2;
	localparam int FREQ_W  = 16;
	localparam int THR_W   = 7;
	localparam int CNT_W   = 16;
	localparam int LEVEL_W = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Stream payload widths, padded to whole bytes.
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 32;

	// Operation codes carried in the input tuser.
	localparam logic [OP_W-1:0] OP_MEASURE = 2'd0;
	localparam logic [OP_W-1:0] OP_TICK    = 2'd1;
	localparam logic [OP_W-1:0] OP_RECAL   = 2'd2;
	localparam logic [OP_W-1:0] OP_ACK     = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SILENCE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_LIM  = 2'd2;

	// Configuration reset values.
	localparam logic [THR_W-1:0] THRESHOLD_RST = 7'd5;
	localparam logic [CNT_W-1:0] SILENCE_RST   = 16'd225;
	localparam logic [CNT_W-1:0] TIME_LIM_RST  = 16'd150;

	// Percent scale; a frequency at or below this is a sensor fault too.
	localparam logic [THR_W-1:0]  PCT_FULL  = 7'd100;
	localparam logic [FREQ_W-1:0] FAULT_MAX = 16'd100;

	// Scaled product freq * (100 - thr) fits in 23 bits.
	localparam int PROD_W = FREQ_W + THR_W;

	// floor(p / 100) = (p * RECIP_100) >> RECIP_SHIFT, exact for p < 2^23.
	localparam int RECIP_W     = 24;
	localparam int RECIP_SHIFT = 30;
	localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;
	localparam int QPROD_W = PROD_W + RECIP_W;

endpackage

>>> hw/rtl/leak_alarm_qualifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Leak alarm qualifier
// Qualifies leak sensor measurements, manages baseline calibration, the
// alarm qualification counter, the alarm timer and the silence countdown.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    in         tdata: frequency, external_alarm, mains_power;
//                      tuser: op
// m_axis    out        tdata: alarm_active, silenced, calibrated,
//                      sensor_fault, baseline_level, alarm_level
// cfg       in         cfg_we, cfg_index, cfg_wdata (no read-back)
//
// Each beat passes an input stage that forms freq * (100 - threshold),
// then the update that divides by 100 with a reciprocal multiply and
// writes the state and result register. A new beat is accepted every
// cycle while m_axis is not stalled. When m_axis stalls, the result holds
// and the input stage holds one more beat before s_axis_tready drops.
// arst_n clears all state and restores the register reset values.
// ----------------------------------------------------------------------------
module leak_alarm_qualifier #(
	parameter int QUAL_MIN  = 3,
	parameter int TIMER_MAX = 65535
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input stream.
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [15:0] frequency, [16] external_alarm, [17] mains_power
	input  logic [laq_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// [1:0] op
	input  logic [laq_pkg::OP_W-1:0]          s_axis_tuser,
	// Result stream.
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [0] alarm_active, [1] silenced, [2] calibrated, [3] sensor_fault,
	// [19:4] baseline_level, [27:20] alarm_level
	output logic [laq_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// Configuration write port.
	input  logic                              cfg_we,
	input  logic [laq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [laq_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	localparam logic [laq_pkg::LEVEL_W-1:0] QUAL_MIN_L = laq_pkg::LEVEL_W'(QUAL_MIN);
	localparam logic [laq_pkg::LEVEL_W-1:0] QUAL_TOP   = laq_pkg::LEVEL_W'(2 * QUAL_MIN);
	localparam logic [laq_pkg::CNT_W-1:0]   TIMER_TOP  = laq_pkg::CNT_W'(TIMER_MAX);

	// Configuration registers.
	logic [laq_pkg::THR_W-1:0] threshold_q;
	logic [laq_pkg::CNT_W-1:0] silence_ticks_q;
	logic [laq_pkg::CNT_W-1:0] time_limit_q;

	// Block state.
	logic                        calibrated_q;
	logic [laq_pkg::FREQ_W-1:0]  baseline_q;
	logic [laq_pkg::LEVEL_W-1:0] qual_q;
	logic [laq_pkg::CNT_W-1:0]   silence_q;
	logic [laq_pkg::CNT_W-1:0]   timer_q;

	// Input stage.
	logic                        valid_s1;
	logic [laq_pkg::OP_W-1:0]    op_s1;
	logic [laq_pkg::FREQ_W-1:0]  freq_s1;
	logic                        ext_alarm_s1;
	logic                        ext_power_s1;
	logic [laq_pkg::PROD_W-1:0]  prod_s1;

	// Result register.
	logic                           out_valid_q;
	logic [laq_pkg::OUT_DATA_W-1:0] out_data_q;

	logic                        in_beat;
	logic                        advance;
	logic [laq_pkg::THR_W-1:0]   thr_clamp;
	logic [laq_pkg::THR_W-1:0]   scale;
	logic [laq_pkg::PROD_W-1:0]  prod_in;
	logic [laq_pkg::QPROD_W-1:0] qprod;
	logic [laq_pkg::FREQ_W-1:0]  quot;

	logic                        cal_d;
	logic [laq_pkg::FREQ_W-1:0]  base_d;
	logic [laq_pkg::LEVEL_W-1:0] qual_d;
	logic [laq_pkg::CNT_W-1:0]   sil_d;
	logic [laq_pkg::CNT_W-1:0]   timer_d;
	logic                        fault_d;

	// Handshake: the input stage moves on when the result register is free.
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_beat       = s_axis_tvalid && s_axis_tready;

	// Scaled dry level; thresholds above 100 act as 100.
	assign thr_clamp = (threshold_q > laq_pkg::PCT_FULL) ? laq_pkg::PCT_FULL : threshold_q;
	assign scale     = laq_pkg::PCT_FULL - thr_clamp;
	assign prod_in   = laq_pkg::PROD_W'(s_axis_tdata[laq_pkg::FREQ_W-1:0]) *
	                   laq_pkg::PROD_W'(scale);

	// Divide the registered product by 100.
	assign qprod = laq_pkg::QPROD_W'(prod_s1) * laq_pkg::QPROD_W'(laq_pkg::RECIP_100);
	assign quot  = qprod[laq_pkg::RECIP_SHIFT +: laq_pkg::FREQ_W];

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q     <= laq_pkg::THRESHOLD_RST;
			silence_ticks_q <= laq_pkg::SILENCE_RST;
			time_limit_q    <= laq_pkg::TIME_LIM_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				laq_pkg::REG_THRESHOLD: threshold_q     <= cfg_wdata[laq_pkg::THR_W-1:0];
				laq_pkg::REG_SILENCE:   silence_ticks_q <= cfg_wdata;
				laq_pkg::REG_TIME_LIM:  time_limit_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_beat) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (in_beat) begin
			op_s1        <= s_axis_tuser;
			freq_s1      <= s_axis_tdata[laq_pkg::FREQ_W-1:0];
			ext_alarm_s1 <= s_axis_tdata[laq_pkg::FREQ_W];
			ext_power_s1 <= s_axis_tdata[laq_pkg::FREQ_W+1];
			prod_s1      <= prod_in;
		end
	end

	// Next state for the beat in the input stage.
	always_comb begin
		logic [laq_pkg::CNT_W-1:0] timer_inc;
		timer_inc = timer_q + laq_pkg::CNT_W'(1);
		cal_d   = calibrated_q;
		base_d  = baseline_q;
		qual_d  = qual_q;
		sil_d   = silence_q;
		timer_d = timer_q;
		fault_d = 1'b0;
		case (op_s1)
			laq_pkg::OP_MEASURE: begin
				if (!calibrated_q) begin
					if (freq_s1 > laq_pkg::FAULT_MAX) begin
						base_d = quot;
						qual_d = '0;
						cal_d  = 1'b1;
					end else begin
						qual_d  = QUAL_TOP;
						fault_d = 1'b1;
					end
				end else begin
					if (freq_s1 <= laq_pkg::FAULT_MAX) begin
						qual_d  = QUAL_TOP;
						fault_d = 1'b1;
					end
					if ((freq_s1 < baseline_q || ext_alarm_s1) && silence_q == '0) begin
						if (qual_d < QUAL_TOP) begin
							qual_d = qual_d + laq_pkg::LEVEL_W'(1);
						end
						if (qual_d > QUAL_MIN_L && timer_q == '0 && !ext_power_s1) begin
							timer_d = laq_pkg::CNT_W'(1);
						end
					end else if (qual_d != '0) begin
						qual_d = qual_d - laq_pkg::LEVEL_W'(1);
					end
				end
			end
			laq_pkg::OP_TICK: begin
				if (silence_q != '0) begin
					sil_d = silence_q - laq_pkg::CNT_W'(1);
				end
				if (timer_q != '0 && timer_q < TIMER_TOP) begin
					timer_d = timer_inc;
					// Alarm sounded too long: silence it automatically.
					if (timer_inc > time_limit_q) begin
						sil_d   = silence_ticks_q;
						qual_d  = '0;
						timer_d = '0;
					end
				end
			end
			laq_pkg::OP_RECAL: begin
				cal_d = 1'b0;
			end
			laq_pkg::OP_ACK: begin
				if (qual_q > QUAL_MIN_L) begin
					sil_d   = silence_ticks_q;
					qual_d  = '0;
					timer_d = '0;
				end else begin
					cal_d = 1'b0;
				end
			end
			default: ;
		endcase
	end

	// State update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calibrated_q <= 1'b0;
			baseline_q   <= '0;
			qual_q       <= '0;
			silence_q    <= '0;
			timer_q      <= '0;
		end else if (advance) begin
			calibrated_q <= cal_d;
			baseline_q   <= base_d;
			qual_q       <= qual_d;
			silence_q    <= sil_d;
			timer_q      <= timer_d;
		end
	end

	// Result register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {4'b0000, qual_d, base_d, fault_d, cal_d,
			               (sil_d != '0), (qual_d > QUAL_MIN_L)};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// The qualification counter never passes its saturation point.
	a_level_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[27:20] <= QUAL_TOP))
		else $error("alarm level above saturation");

	// Alarm flag agrees with the reported level.
	a_active_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[27:20] > QUAL_MIN_L)))
		else $error("alarm flag does not match level");

	// Only measurements can report a sensor fault.
	a_fault_op: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && fault_d) |-> (op_s1 == laq_pkg::OP_MEASURE))
		else $error("sensor fault on a non-measurement beat");

	// A stalled input stage keeps its beat.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(prod_s1) && $stable(op_s1)))
		else $error("input stage lost a stalled beat");

endmodule

>>> tb/sv/laq_result_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Leak alarm qualifier result check
// Watches the input, result and register write channels of the qualifier.
// It keeps its own copy of the calibration, counter, timer and silence state.
// For every accepted input beat it computes the expected result beat and
// compares each accepted result beat field by field with the oldest one.
// ----------------------------------------------------------------------------
module laq_result_check #(
	parameter int QUAL_MIN  = 3,
	parameter int TIMER_MAX = 65535
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	input  logic                              s_axis_tready,
	// [15:0] frequency, [16] external_alarm, [17] mains_power
	input  logic [laq_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// [1:0] op
	input  logic [laq_pkg::OP_W-1:0]          s_axis_tuser,
	input  logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [0] alarm_active, [1] silenced, [2] calibrated, [3] sensor_fault,
	// [19:4] baseline_level, [27:20] alarm_level
	input  logic [laq_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	input  logic                              cfg_we,
	input  logic [laq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [laq_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output int                                fail_count,
	output int                                outstanding
);
	import laq_pkg::*;

	localparam int                 PCT      = int'(PCT_FULL);
	localparam logic [LEVEL_W-1:0] QUAL_TOP = LEVEL_W'(2 * QUAL_MIN);

	typedef struct packed {
		logic               alarm_active;
		logic               silenced;
		logic               calibrated;
		logic               sensor_fault;
		logic [FREQ_W-1:0]  baseline_level;
		logic [LEVEL_W-1:0] alarm_level;
	} alarm_status_t;

	// Register copies.
	logic [THR_W-1:0]   threshold_reg;
	logic [CNT_W-1:0]   silence_ticks_reg;
	logic [CNT_W-1:0]   time_limit_reg;

	// Qualifier state copies.
	logic               is_cal;
	logic [FREQ_W-1:0]  base_lvl;
	logic [LEVEL_W-1:0] qual_cnt;
	logic [CNT_W-1:0]   silence_cnt;
	logic [CNT_W-1:0]   alarm_tmr;

	alarm_status_t      status_q[$];
	alarm_status_t      want;
	alarm_status_t      got;

	// Silencing clears the counter and the timer and starts the countdown.
	function automatic void silence_alarm();
		silence_cnt = silence_ticks_reg;
		qual_cnt    = '0;
		alarm_tmr   = '0;
	endfunction

	// Applies one input beat to the state copy and returns the status beat.
	function automatic alarm_status_t qualify_beat(logic [OP_W-1:0] op,
			logic [FREQ_W-1:0] freq, logic ext_alarm, logic ext_power);
		alarm_status_t st;
		int            thr_eff;
		logic          fault;
		fault = 1'b0;
		case (op)
		OP_MEASURE: begin
			if (!is_cal) begin
				// A good first measurement sets the dry baseline.
				if (freq > FAULT_MAX) begin
					thr_eff  = (int'(threshold_reg) > PCT) ? PCT : int'(threshold_reg);
					base_lvl = FREQ_W'((int'(freq) * (PCT - thr_eff)) / PCT);
					qual_cnt = '0;
					is_cal   = 1'b1;
				end else begin
					qual_cnt = QUAL_TOP;
					fault    = 1'b1;
				end
			end else begin
				// A fault forces the counter up, then the usual step follows.
				if (freq <= FAULT_MAX) begin
					qual_cnt = QUAL_TOP;
					fault    = 1'b1;
				end
				if ((freq < base_lvl || ext_alarm) && silence_cnt == '0) begin
					if (qual_cnt < QUAL_TOP)
						qual_cnt = qual_cnt + 1'b1;
					if (int'(qual_cnt) > QUAL_MIN && alarm_tmr == '0 && !ext_power)
						alarm_tmr = CNT_W'(1);
				end else if (qual_cnt != '0) begin
					qual_cnt = qual_cnt - 1'b1;
				end
			end
		end
		OP_TICK: begin
			if (silence_cnt != '0)
				silence_cnt = silence_cnt - 1'b1;
			// The timer runs only once started and stops at its maximum.
			if (alarm_tmr != '0 && int'(alarm_tmr) < TIMER_MAX) begin
				alarm_tmr = alarm_tmr + 1'b1;
				if (alarm_tmr > time_limit_reg)
					silence_alarm();
			end
		end
		OP_RECAL: begin
			is_cal = 1'b0;
		end
		OP_ACK: begin
			if (int'(qual_cnt) > QUAL_MIN)
				silence_alarm();
			else
				is_cal = 1'b0;
		end
		default: ;
		endcase
		st.alarm_active   = int'(qual_cnt) > QUAL_MIN;
		st.silenced       = silence_cnt != '0;
		st.calibrated     = is_cal;
		st.sensor_fault   = fault;
		st.baseline_level = base_lvl;
		st.alarm_level    = qual_cnt;
		return st;
	endfunction

	// Returns one when a field differs, after reporting it.
	function automatic int field_differs(string name, int exp_val, int act_val);
		if (exp_val != act_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			return 1;
		end
		return 0;
	endfunction

	// Register writes, prediction on input beats, comparison on result beats.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_reg     = THRESHOLD_RST;
			silence_ticks_reg = SILENCE_RST;
			time_limit_reg    = TIME_LIM_RST;
			is_cal            = 1'b0;
			base_lvl          = '0;
			qual_cnt          = '0;
			silence_cnt       = '0;
			alarm_tmr         = '0;
			status_q.delete();
			fail_count        = 0;
			outstanding       = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				REG_THRESHOLD: threshold_reg     = cfg_wdata[THR_W-1:0];
				REG_SILENCE:   silence_ticks_reg = cfg_wdata;
				REG_TIME_LIM:  time_limit_reg    = cfg_wdata;
				default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{alarm_active: m_axis_tdata[0], silenced: m_axis_tdata[1],
					calibrated: m_axis_tdata[2], sensor_fault: m_axis_tdata[3],
					baseline_level: m_axis_tdata[19:4], alarm_level: m_axis_tdata[27:20]};
				if (status_q.size() == 0) begin
					$error("result beat arrived with no expected beat waiting");
					fail_count++;
				end else begin
					want = status_q.pop_front();
					fail_count += field_differs("alarm_active", want.alarm_active,
						got.alarm_active);
					fail_count += field_differs("silenced", want.silenced, got.silenced);
					fail_count += field_differs("calibrated", want.calibrated,
						got.calibrated);
					fail_count += field_differs("sensor_fault", want.sensor_fault,
						got.sensor_fault);
					fail_count += field_differs("baseline_level", want.baseline_level,
						got.baseline_level);
					fail_count += field_differs("alarm_level", want.alarm_level,
						got.alarm_level);
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				status_q.push_back(qualify_beat(s_axis_tuser, s_axis_tdata[15:0],
					s_axis_tdata[16], s_axis_tdata[17]));
			outstanding = status_q.size();
		end
	end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Leak alarm qualifier testbench
// Drives a directed sequence through calibration, faults, alarm raise,
// timer start and acknowledge, then random measurement runs of dry and wet
// levels mixed with ticks, recalibrations and acknowledges under several
// register settings and flow-control patterns. A separate check module
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench;
	import laq_pkg::*;

	localparam int QUAL_MIN       = 3;
	localparam int TIMER_MAX      = 65535;
	localparam int CHUNKS         = 6;
	localparam int CHUNK_ITEMS    = 155;
	localparam int SETTLE_CYCLES  = 4;
	localparam int CYCLE_LIMIT    = 400000;
	// Index past the last register; writes to it must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
	logic [OP_W-1:0]        s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_axis_tdata;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

	int                     fail_count;
	int                     outstanding;
	int                     cycle_count = 0;
	int                     tx_idle_pct = 17;
	int                     rx_idle_pct = 87;
	int                     run_left = 0;
	logic                   run_wet = 1'b0;
	int                     chunk;
	logic [CFG_DATA_W-1:0]  thr_val;
	logic [CFG_DATA_W-1:0]  sil_val;
	logic [CFG_DATA_W-1:0]  lim_val;
	logic [FREQ_W-1:0]      dry_level;

	leak_alarm_qualifier #(
		.QUAL_MIN (QUAL_MIN),
		.TIMER_MAX(TIMER_MAX)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	laq_result_check #(
		.QUAL_MIN (QUAL_MIN),
		.TIMER_MAX(TIMER_MAX)
	) result_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// The result side stalls at random.
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Offers one input beat after a random gap and waits until it is taken.
	task automatic send_item(input logic [OP_W-1:0] op, input logic [FREQ_W-1:0] freq,
			input logic ext_alarm, input logic ext_power);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_DATA_W'({ext_power, ext_alarm, freq});
		s_axis_tuser  <= op;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// Random beat: measurements come in dry or wet runs so the counter climbs.
	task automatic send_random_item(input logic [FREQ_W-1:0] dry);
		int                pick;
		logic [OP_W-1:0]   op;
		logic [FREQ_W-1:0] freq;
		logic              ext_alarm;
		logic              ext_power;
		pick      = $urandom_range(99);
		ext_alarm = ($urandom_range(99) < 8);
		ext_power = ($urandom_range(99) < 30);
		freq      = FREQ_W'($urandom);
		if (pick < 62) begin
			op = OP_MEASURE;
			if (run_left == 0) begin
				run_wet  = ($urandom_range(99) < 45);
				run_left = $urandom_range(2, 12);
			end
			run_left--;
			pick = $urandom_range(99);
			if (pick < 6)
				freq = FREQ_W'($urandom_range(int'(FAULT_MAX)));
			else if (pick >= 14 && run_wet)
				freq = FREQ_W'($urandom_range(int'(FAULT_MAX) + 1, int'(dry) / 2));
			else if (pick >= 14)
				freq = FREQ_W'($urandom_range(int'(dry), 65535));
		end else if (pick < 91) begin
			op = OP_TICK;
		end else if (pick < 94) begin
			op = OP_RECAL;
		end else begin
			op = OP_ACK;
		end
		send_item(op, freq, ext_alarm, ext_power);
	endtask

	// Waits until every expected beat is back and the pipeline has emptied.
	task automatic wait_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed sequence on the reset register values.
		send_item(OP_TICK, 16'd0, 1'b0, 1'b0);          // tick with timer stopped
		send_item(OP_ACK, 16'd0, 1'b0, 1'b0);           // acknowledge with no alarm
		send_item(OP_MEASURE, 16'd0, 1'b0, 1'b0);       // fault while uncalibrated
		send_item(OP_MEASURE, FAULT_MAX, 1'b1, 1'b1);   // fault at the limit
		send_item(OP_MEASURE, 16'd101, 1'b0, 1'b0);     // lowest good level calibrates
		send_item(OP_MEASURE, 16'hFFFF, 1'b1, 1'b1);    // external alarm raises
		send_item(OP_MEASURE, 16'd1000, 1'b0, 1'b0);    // dry level lets it fall
		send_item(OP_MEASURE, 16'd90, 1'b0, 1'b0);      // fault while checking
		send_item(OP_TICK, 16'd0, 1'b0, 1'b0);          // timer advances
		send_item(OP_MEASURE, 16'hFFFF, 1'b0, 1'b0);
		send_item(OP_RECAL, 16'd0, 1'b0, 1'b0);         // counter kept while uncalibrated
		send_item(OP_MEASURE, 16'd20000, 1'b0, 1'b1);
		repeat (4) send_item(OP_MEASURE, 16'd5000, 1'b0, 1'b1);
		send_item(OP_TICK, 16'd0, 1'b0, 1'b0);
		send_item(OP_ACK, 16'd0, 1'b0, 1'b0);           // acknowledge silences
		send_item(OP_MEASURE, 16'd5000, 1'b0, 1'b0);    // wet while silenced does not raise
		send_item(OP_MEASURE, 16'd0, 1'b0, 1'b0);       // fault while silenced
		send_item(OP_TICK, 16'd0, 1'b0, 1'b0);
		send_item(OP_ACK, 16'd0, 1'b0, 1'b0);

		// Random runs, each under its own register setting.
		for (chunk = 0; chunk < CHUNKS; chunk++) begin
			case (chunk)
			0: begin
				thr_val = 16'd0;
				sil_val = 16'd0;
				lim_val = 16'd0;
			end
			1: begin
				// Threshold is masked to 127 and treated as full scale.
				thr_val = 16'hFFFF;
				sil_val = 16'hFFFF;
				lim_val = 16'hFFFF;
			end
			2: begin
				thr_val = 16'd100;
				sil_val = 16'd5;
				lim_val = 16'd3;
			end
			default: begin
				thr_val = CFG_DATA_W'($urandom_range(127));
				sil_val = CFG_DATA_W'($urandom_range(40));
				lim_val = CFG_DATA_W'($urandom_range(40));
			end
			endcase
			tx_idle_pct = (chunk < 2) ? 17 : (chunk < 4) ? 87 : 0;
			rx_idle_pct = (chunk < 2) ? 87 : (chunk < 4) ? 17 : 0;
			wait_idle();
			write_reg(REG_THRESHOLD, thr_val);
			write_reg(REG_SILENCE, sil_val);
			write_reg(REG_TIME_LIM, lim_val);
			if (chunk == 0)
				write_reg(REG_SPARE, CFG_DATA_W'($urandom));
			@(negedge clk);
			cfg_we <= 1'b0;
			dry_level = FREQ_W'($urandom_range(4000, 65535));
			run_left  = 0;
			repeat (CHUNK_ITEMS) send_random_item(dry_level);
		end

		wait_idle();
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
